### hw/rtl/frc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package frc_pkg;

	// Block geometry
	localparam int NUM_PLANES  = 6;
	localparam int NUM_CORNERS = 8;
	localparam int CORNER_W    = 48;
	localparam int PLANE_W     = 64;
	localparam int CFG_IDX_W   = 3;

	// Default lane widths
	localparam int COORD_WIDTH_DEF = 16;
	localparam int COEF_WIDTH_DEF  = 16;

	// Query kinds
	localparam logic FUNC_BOX   = 1'b0;
	localparam logic FUNC_POINT = 1'b1;

	typedef logic [NUM_PLANES-1:0][PLANE_W-1:0]    plane_arr_t;
	typedef logic [NUM_CORNERS-1:0][CORNER_W-1:0]  corner_arr_t;
	typedef logic [NUM_PLANES-1:0][NUM_CORNERS-1:0] sign_map_t;

	// Pipeline load enables shared by all lanes
	typedef struct packed {
		logic adv_s1;
		logic adv_s2;
		logic adv_s3;
	} pipe_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/frc_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module frc_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [frc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [frc_pkg::PLANE_W-1:0]      cfg_wdata,
	output frc_pkg::plane_arr_t                   planes
);
	import frc_pkg::*;

	plane_arr_t plane_q;

	// Write the addressed plane; indexes past the last plane drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (cfg_we) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				if (cfg_index == CFG_IDX_W'(i)) begin
					plane_q[i] <= cfg_wdata;
				end
			end
		end
	end

	assign planes = plane_q;

endmodule

`default_nettype wire

### hw/rtl/frc_dot_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module frc_dot_lane #(
	parameter int COORD_WIDTH = frc_pkg::COORD_WIDTH_DEF,
	parameter int COEF_WIDTH  = frc_pkg::COEF_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire frc_pkg::pipe_ctrl_t         ctrl,
	input  wire logic [frc_pkg::PLANE_W-1:0] plane,
	input  wire logic [frc_pkg::CORNER_W-1:0] corner,
	output logic                             gt_s2,
	output logic                             lt_s2
);
	import frc_pkg::*;

	localparam int PAD_W  = 3 * COORD_WIDTH;
	localparam int PROD_W = COEF_WIDTH + COORD_WIDTH;
	localparam int SUM_W  = PROD_W + 2;

	logic [PAD_W-1:0]              cpad;
	logic signed [COORD_WIDTH-1:0] x, y, z;
	logic signed [COEF_WIDTH-1:0]  a, b, c, d;
	logic signed [PROD_W-1:0]      ax_s1, by_s1, cz_s1;
	logic signed [COEF_WIDTH-1:0]  d_s1;
	logic signed [SUM_W-1:0]       sum;

	// Unpack lanes; coordinate bits above the corner field read as zero
	assign cpad = PAD_W'({{PAD_W{1'b0}}, corner});
	assign x = signed'(cpad[0 +: COORD_WIDTH]);
	assign y = signed'(cpad[COORD_WIDTH +: COORD_WIDTH]);
	assign z = signed'(cpad[2*COORD_WIDTH +: COORD_WIDTH]);
	assign a = signed'(plane[0 +: COEF_WIDTH]);
	assign b = signed'(plane[COEF_WIDTH +: COEF_WIDTH]);
	assign c = signed'(plane[2*COEF_WIDTH +: COEF_WIDTH]);
	assign d = signed'(plane[3*COEF_WIDTH +: COEF_WIDTH]);

	// Stage 1: register the three products and the offset
	always_ff @(posedge clk) begin
		if (ctrl.adv_s1) begin
			ax_s1 <= PROD_W'(a * x);
			by_s1 <= PROD_W'(b * y);
			cz_s1 <= PROD_W'(c * z);
			d_s1  <= d;
		end
	end

	// Stage 2: exact sum, keep only its sign
	assign sum = SUM_W'(ax_s1) + SUM_W'(by_s1) + SUM_W'(cz_s1) + SUM_W'(d_s1);

	always_ff @(posedge clk) begin
		if (ctrl.adv_s2) begin
			gt_s2 <= !sum[SUM_W-1] && (sum != '0);
			lt_s2 <= sum[SUM_W-1];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/frc_verdict.sv
`timescale 1ns / 1ps
`default_nettype none

module frc_verdict (
	input  wire logic                clk,
	input  wire frc_pkg::pipe_ctrl_t ctrl,
	input  wire logic                func_s2,
	input  wire frc_pkg::sign_map_t  gt_s2,
	input  wire frc_pkg::sign_map_t  lt_s2,
	output logic                     visible_s3
);
	import frc_pkg::*;

	logic [NUM_PLANES-1:0] plane_hit;
	logic [NUM_PLANES-1:0] point_out;
	logic                  box_vis;
	logic                  point_vis;

	// Box passes a plane if any corner lies strictly inside it; a point fails a plane if corner 0 lies strictly outside it
	always_comb begin
		for (int p = 0; p < NUM_PLANES; p++) begin
			plane_hit[p] = |gt_s2[p];
			point_out[p] = lt_s2[p][0];
		end
	end

	assign box_vis   = &plane_hit;
	assign point_vis = ~|point_out;

	// Stage 3: select the verdict for the query kind
	always_ff @(posedge clk) begin
		if (ctrl.adv_s3) begin
			visible_s3 <= (func_s2 == FUNC_POINT) ? point_vis : box_vis;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/frustum_box_cull.sv
// Six-plane view-frustum cull for an axis box given by eight corners or for a
// single point. Load the six planes through the write port while no
// transaction is in flight; then one query may enter every clock while
// in_stall is low. Stage 1 forms all 144 coefficient by coordinate
// products (six planes times eight corners, one lane each), stage 2 sums
// each lane exactly and keeps its sign, stage 3 reduces the signs to the
// visible bit and holds it in the output register. A stall from the
// consumer backs up only as far as the pipeline is full, so the input stays
// open while empty stages remain.
`timescale 1ns / 1ps
`default_nettype none

module frustum_box_cull #(
	parameter int COORD_WIDTH = frc_pkg::COORD_WIDTH_DEF,
	parameter int COEF_WIDTH  = frc_pkg::COEF_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [frc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [frc_pkg::PLANE_W-1:0]   cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          func,
	input  wire logic [frc_pkg::CORNER_W-1:0]  corner_0,
	input  wire logic [frc_pkg::CORNER_W-1:0]  corner_1,
	input  wire logic [frc_pkg::CORNER_W-1:0]  corner_2,
	input  wire logic [frc_pkg::CORNER_W-1:0]  corner_3,
	input  wire logic [frc_pkg::CORNER_W-1:0]  corner_4,
	input  wire logic [frc_pkg::CORNER_W-1:0]  corner_5,
	input  wire logic [frc_pkg::CORNER_W-1:0]  corner_6,
	input  wire logic [frc_pkg::CORNER_W-1:0]  corner_7,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               visible
);
	import frc_pkg::*;

	plane_arr_t  planes;
	corner_arr_t corners;
	sign_map_t   gt_s2;
	sign_map_t   lt_s2;
	pipe_ctrl_t  ctrl;

	logic vld_s1, vld_s2, vld_s3;
	logic rdy_s1, rdy_s2, rdy_s3;
	logic func_s1, func_s2;

	assign corners = {corner_7, corner_6, corner_5, corner_4,
	                  corner_3, corner_2, corner_1, corner_0};

	// Plane registers
	frc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.planes    (planes)
	);

	// A stage takes new data when it is empty or its successor moves on
	assign rdy_s3 = !vld_s3 || !out_stall;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;

	assign ctrl.adv_s1 = in_valid && rdy_s1;
	assign ctrl.adv_s2 = vld_s1 && rdy_s2;
	assign ctrl.adv_s3 = vld_s2 && rdy_s3;

	assign in_stall = !rdy_s1;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= in_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	// Carry the query kind alongside the lanes
	always_ff @(posedge clk) begin
		if (ctrl.adv_s1) begin
			func_s1 <= func;
		end
		if (ctrl.adv_s2) begin
			func_s2 <= func_s1;
		end
	end

	// One dot-product lane per plane and corner
	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
		for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_corner
			frc_dot_lane #(
				.COORD_WIDTH (COORD_WIDTH),
				.COEF_WIDTH  (COEF_WIDTH)
			) u_lane (
				.clk    (clk),
				.ctrl   (ctrl),
				.plane  (planes[p]),
				.corner (corners[k]),
				.gt_s2  (gt_s2[p][k]),
				.lt_s2  (lt_s2[p][k])
			);
		end
	end

	// Reduce signs to the verdict
	frc_verdict u_verdict (
		.clk        (clk),
		.ctrl       (ctrl),
		.func_s2    (func_s2),
		.gt_s2      (gt_s2),
		.lt_s2      (lt_s2),
		.visible_s3 (visible)
	);

	assign out_valid = vld_s3;

	// Input only backs up when every stage holds a transaction
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld_s1 && vld_s2 && vld_s3))
		else $error("input stalled with an empty stage");

	// A free consumer never stalls the input
	a_free_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output drains");

	// An accepted transaction occupies stage 1 next cycle
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.adv_s1 |=> vld_s1)
		else $error("accepted transaction lost at stage 1");

	// A blocked stage 1 holds its transaction and kind
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !rdy_s2) |=> (vld_s1 && $stable(func_s1)))
		else $error("stage 1 changed while blocked");

endmodule

`default_nettype wire
